>>> design/adp_pkg.sv
// ----------------------------------------------------------------------------
// adp_pkg
// Shared constants, word types and control structs for the ArtDmx receiver.
// ----------------------------------------------------------------------------
package adp_pkg;

  // Sizes
  localparam int MAX_CHANNELS     = 512;
  localparam int MAX_PACKET_BYTES = 1024;
  localparam int ADDR_W           = $clog2(MAX_CHANNELS);
  localparam int CNT_W            = $clog2(MAX_CHANNELS + 1);
  localparam int POS_W            = $clog2(MAX_PACKET_BYTES + 1);

  // Packet layout
  localparam int ID_BYTES         = 8;
  localparam int OPC_LO_POS       = 8;
  localparam int OPC_HI_POS       = 9;
  localparam int MIN_OPCODE_BYTES = 10;
  localparam int ADDR_POS         = 14;
  localparam int LEN_HI_POS       = 16;
  localparam int LEN_LO_POS       = 17;
  localparam int DATA_POS         = 18;

  localparam logic [15:0] OP_POLL = 16'h2000;
  localparam logic [15:0] OP_DMX  = 16'h5000;

  // Request opcodes
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Result kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  // Packet status codes
  localparam logic [1:0] STAT_NONE    = 2'd0;
  localparam logic [1:0] STAT_POLL    = 2'd1;
  localparam logic [1:0] STAT_IGNORED = 2'd2;
  localparam logic [1:0] STAT_APPLIED = 2'd3;

  // Config register indexes
  localparam logic CFG_SUBNET   = 1'b0;
  localparam logic CFG_UNIVERSE = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [7:0] data_byte;
    logic       last_byte;
    logic [8:0] channel_index;
  } req_t;

  typedef struct packed {
    logic        result_kind;
    logic [1:0]  status;
    logic [15:0] packet_opcode;
    logic [9:0]  channels_written;
    logic [7:0]  channel_value;
  } rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic take_byte;
    logic read_req;
    logic finish;
    logic fill_step;
    logic clear_step;
    logic load_read;
    logic load_status;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_done;
    logic fill_needed;
    logic fill_last;
    logic out_free;
  } dp_stat_t;

  // "Art-Net" followed by a zero byte
  function automatic logic [7:0] id_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h41;
      3'd1:    c = 8'h72;
      3'd2:    c = 8'h74;
      3'd3:    c = 8'h2d;
      3'd4:    c = 8'h4e;
      3'd5:    c = 8'h65;
      3'd6:    c = 8'h74;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

>>> design/adp_datapath.sv
// ----------------------------------------------------------------------------
// adp_datapath
// Header parsing registers, frame store, sweep counter and result register.
// ----------------------------------------------------------------------------
module adp_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [3:0]          cfg_data,
  input  adp_pkg::req_t       req,
  input  adp_pkg::ctrl_cmd_t  cmd,
  output adp_pkg::dp_stat_t   stat,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output adp_pkg::rsp_t       rsp
);

  // Config
  logic [3:0] subnet_sel;
  logic [3:0] universe_sel;

  // Per-packet state
  logic [adp_pkg::POS_W-1:0] byte_position;
  logic                      header_ok;
  logic [15:0]               opcode_word;
  logic                      address_match;
  logic [15:0]               data_length;

  // Shared clear/fill pointer
  logic [adp_pkg::CNT_W-1:0] sweep_ptr;

  // Finished packet result
  logic [1:0]  pending_status;
  logic [15:0] pending_op;
  logic [9:0]  pending_written;

  // Frame store
  logic [7:0] mem [adp_pkg::MAX_CHANNELS];
  logic [7:0] rd_data;
  logic       rd_oob;

  logic                       mem_we;
  logic [adp_pkg::ADDR_W-1:0] mem_addr;
  logic [7:0]                 mem_wdata;

  logic                      length_ok;
  logic                      dmx_ok;
  logic [adp_pkg::POS_W-1:0] chan;
  logic                      in_range;
  logic                      store_byte;
  logic                      has_opcode;
  logic                      applied;
  logic [1:0]                fin_status;

  // Register file
  always_ff @(posedge clk) begin
    if (rst) begin
      subnet_sel   <= '0;
      universe_sel <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        adp_pkg::CFG_SUBNET:   subnet_sel   <= cfg_data;
        adp_pkg::CFG_UNIVERSE: universe_sel <= cfg_data;
        default:               subnet_sel   <= subnet_sel;
      endcase
    end
  end

  // Packet qualification
  always_comb begin
    length_ok  = (data_length >= 16'd2) && (data_length <= 16'(adp_pkg::MAX_CHANNELS));
    dmx_ok     = header_ok && (opcode_word == adp_pkg::OP_DMX) && address_match && length_ok;
    chan       = byte_position - adp_pkg::POS_W'(adp_pkg::DATA_POS);
    in_range   = byte_position < adp_pkg::POS_W'(adp_pkg::MAX_PACKET_BYTES);
    store_byte = cmd.take_byte && in_range
              && (byte_position >= adp_pkg::POS_W'(adp_pkg::DATA_POS))
              && dmx_ok && (16'(chan) < data_length)
              && (chan < adp_pkg::POS_W'(adp_pkg::MAX_CHANNELS));
    has_opcode = byte_position >= adp_pkg::POS_W'(adp_pkg::MIN_OPCODE_BYTES);
    applied    = dmx_ok && (byte_position > adp_pkg::POS_W'(adp_pkg::DATA_POS));
    fin_status = adp_pkg::STAT_NONE;
    if (has_opcode && header_ok) begin
      if (opcode_word == adp_pkg::OP_POLL) begin
        fin_status = adp_pkg::STAT_POLL;
      end else if (opcode_word == adp_pkg::OP_DMX) begin
        fin_status = applied ? adp_pkg::STAT_APPLIED : adp_pkg::STAT_IGNORED;
      end
    end
  end

  // Status back to the controller
  always_comb begin
    stat.clear_done  = sweep_ptr == adp_pkg::CNT_W'(adp_pkg::MAX_CHANNELS - 1);
    stat.fill_needed = applied && (16'(chan) < data_length);
    stat.fill_last   = (16'(sweep_ptr) + 16'd1) == data_length;
    stat.out_free    = !rsp_valid || !rsp_stall;
  end

  // Header field capture, one byte per accepted word
  always_ff @(posedge clk) begin
    if (rst || cmd.load_status) begin
      byte_position <= '0;
      header_ok     <= 1'b1;
      opcode_word   <= '0;
      address_match <= 1'b0;
      data_length   <= '0;
    end else if (cmd.take_byte && in_range) begin
      byte_position <= byte_position + adp_pkg::POS_W'(1);
      if (byte_position < adp_pkg::POS_W'(adp_pkg::ID_BYTES)) begin
        if (req.data_byte != adp_pkg::id_char(byte_position[2:0])) header_ok <= 1'b0;
      end else if (byte_position == adp_pkg::POS_W'(adp_pkg::OPC_LO_POS)) begin
        opcode_word[7:0] <= req.data_byte;
      end else if (byte_position == adp_pkg::POS_W'(adp_pkg::OPC_HI_POS)) begin
        opcode_word[15:8] <= req.data_byte;
      end else if (byte_position == adp_pkg::POS_W'(adp_pkg::ADDR_POS)) begin
        address_match <= (req.data_byte[7:4] == subnet_sel)
                      && (req.data_byte[3:0] == universe_sel);
      end else if (byte_position == adp_pkg::POS_W'(adp_pkg::LEN_HI_POS)) begin
        data_length[15:8] <= req.data_byte;
      end else if (byte_position == adp_pkg::POS_W'(adp_pkg::LEN_LO_POS)) begin
        data_length[7:0] <= req.data_byte;
      end
    end
  end

  // Sweep pointer: reset clear pass, then zero fill after short packets
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_ptr <= '0;
    end else if (cmd.finish) begin
      sweep_ptr <= chan[adp_pkg::CNT_W-1:0];
    end else if (cmd.clear_step || cmd.fill_step) begin
      sweep_ptr <= sweep_ptr + adp_pkg::CNT_W'(1);
    end
  end

  // Capture packet result
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      pending_status  <= fin_status;
      pending_op      <= has_opcode ? opcode_word : 16'h0000;
      pending_written <= applied ? 10'(data_length) : 10'd0;
    end
  end

  // Single write port shared by data bytes and sweeps
  always_comb begin
    mem_we    = store_byte || cmd.fill_step || cmd.clear_step;
    mem_addr  = store_byte ? chan[adp_pkg::ADDR_W-1:0] : sweep_ptr[adp_pkg::ADDR_W-1:0];
    mem_wdata = store_byte ? req.data_byte : 8'h00;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (cmd.read_req) begin
      rd_data <= mem[req.channel_index[adp_pkg::ADDR_W-1:0]];
      rd_oob  <= 10'(req.channel_index) >= 10'(adp_pkg::MAX_CHANNELS);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load_read) begin
      rsp.result_kind      <= adp_pkg::KIND_READ;
      rsp.status           <= adp_pkg::STAT_NONE;
      rsp.packet_opcode    <= 16'h0000;
      rsp.channels_written <= 10'd0;
      rsp.channel_value    <= rd_oob ? 8'h00 : rd_data;
    end else if (cmd.load_status) begin
      rsp.result_kind      <= adp_pkg::KIND_STATUS;
      rsp.status           <= pending_status;
      rsp.packet_opcode    <= pending_op;
      rsp.channels_written <= pending_written;
      rsp.channel_value    <= 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_read || cmd.load_status) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

`ifndef ASSERT_OFF
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    byte_position <= adp_pkg::POS_W'(adp_pkg::MAX_PACKET_BYTES))
    else $error("byte position ran past packet limit");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    cmd.fill_step |-> (16'(sweep_ptr) < data_length))
    else $error("zero fill beyond data length");

  a_read_clean: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.result_kind == adp_pkg::KIND_READ) |->
      (rsp.status == adp_pkg::STAT_NONE && rsp.packet_opcode == 16'h0000
       && rsp.channels_written == 10'd0))
    else $error("read word carries packet fields");

  a_written_applied: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.result_kind == adp_pkg::KIND_STATUS
     && rsp.status != adp_pkg::STAT_APPLIED) |-> (rsp.channels_written == 10'd0))
    else $error("channel count on a packet that was not applied");
`endif

endmodule

>>> design/adp_ctrl.sv
// ----------------------------------------------------------------------------
// adp_ctrl
// Sequencer: reset clear pass, byte intake, reads, zero fill, result hand-off.
// ----------------------------------------------------------------------------
module adp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  adp_pkg::req_t       req,
  output logic                req_stall,
  input  adp_pkg::dp_stat_t   stat,
  output adp_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_READ   = 6'b000100,
    ST_FINISH = 6'b001000,
    ST_FILL   = 6'b010000,
    ST_SEND   = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (req.opcode == adp_pkg::CMD_READ) begin
            cmd.read_req = 1'b1;
            state_next   = ST_READ;
          end else begin
            cmd.take_byte = 1'b1;
            if (req.last_byte) state_next = ST_FINISH;
          end
        end
      end
      ST_READ: begin
        if (stat.out_free) begin
          cmd.load_read = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = stat.fill_needed ? ST_FILL : ST_SEND;
      end
      ST_FILL: begin
        cmd.fill_step = 1'b1;
        if (stat.fill_last) state_next = ST_SEND;
      end
      ST_SEND: begin
        if (stat.out_free) begin
          cmd.load_status = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

`ifndef ASSERT_OFF
  a_fill_exit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL) |=> (state == ST_FILL || state == ST_SEND))
    else $error("zero fill left without sending status");

  a_end_mark: assert property (@(posedge clk) disable iff (rst)
    (accept && req.opcode == adp_pkg::CMD_BYTE && req.last_byte) |=> (state == ST_FINISH))
    else $error("end of packet not closed out");
`endif

endmodule

>>> design/artnet_dmx_packet_parser_top.sv
// ----------------------------------------------------------------------------
// artnet_dmx_packet_parser_top
// ArtDmx receiver: parses UDP payload bytes and keeps a 512-channel frame.
// ----------------------------------------------------------------------------
// A packet byte without end mark is taken in idle, so a packet streams in at
// one byte per clock while req_stall is low. The end byte is closed out, any
// channels that a short applied DMX packet leaves are zeroed through the
// single write port of the frame store, and the status word is handed off. A
// channel read is looked up in the frame store, then loaded into the result
// word. After reset the frame store is cleared by a pass over all 512 channels
// while req_stall is high; configuration writes are taken throughout. Result
// words wait in an output register; the next request is taken while one waits.
module artnet_dmx_packet_parser_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic [3:0]     cfg_data,
  input  logic           req_valid,
  output logic           req_stall,
  input  adp_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output adp_pkg::rsp_t  rsp
);

  adp_pkg::ctrl_cmd_t cmd;
  adp_pkg::dp_stat_t  stat;

  // Sequencer
  adp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Parser and frame store
  adp_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
